// ===== hdl/cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfb_pkg
// Types, constants and the CRC-16/XMODEM byte update shared by the command
// frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Reset values of the configuration registers
	localparam logic [7:0] HEAD_FIRST_RST  = 8'hA5;
	localparam logic [7:0] HEAD_SECOND_RST = 8'h5A;
	localparam logic [7:0] TAIL_FIRST_RST  = 8'h00;
	localparam logic [7:0] TAIL_SECOND_RST = 8'h00;

	// Configuration register indexes
	localparam int          CFG_IDX_W       = 2;
	localparam logic [1:0]  CFG_HEAD_FIRST  = 2'd0;
	localparam logic [1:0]  CFG_HEAD_SECOND = 2'd1;
	localparam logic [1:0]  CFG_TAIL_FIRST  = 2'd2;
	localparam logic [1:0]  CFG_TAIL_SECOND = 2'd3;

	// Input item modes
	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_PAYLOAD = 1'b1;

	// Byte positions within a frame. A payload item enters at the length-low
	// position, which then carries the payload byte instead.
	localparam int         POS_W       = 4;
	localparam logic [3:0] POS_HEAD0   = 4'd0;
	localparam logic [3:0] POS_HEAD1   = 4'd1;
	localparam logic [3:0] POS_ADDR_HI = 4'd2;
	localparam logic [3:0] POS_ADDR_LO = 4'd3;
	localparam logic [3:0] POS_CMD_HI  = 4'd4;
	localparam logic [3:0] POS_CMD_LO  = 4'd5;
	localparam logic [3:0] POS_LEN_HI  = 4'd6;
	localparam logic [3:0] POS_LEN_LO  = 4'd7;
	localparam logic [3:0] POS_CRC_HI  = 4'd8;
	localparam logic [3:0] POS_CRC_LO  = 4'd9;
	localparam logic [3:0] POS_TAIL0   = 4'd10;
	localparam logic [3:0] POS_TAIL1   = 4'd11;

	typedef struct packed {
		logic        mode;
		logic [15:0] module_address;
		logic [15:0] command_code;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] head_first;
		logic [7:0] head_second;
		logic [7:0] tail_first;
		logic [7:0] tail_second;
	} cfg_regs_t;

	// One byte of CRC-16/XMODEM, MSB first, unrolled over the eight bits.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/cfb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cfb_cfg_regs
// Head and tail byte registers, written through a plain write port.
// ----------------------------------------------------------------------------
module cfb_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data,
	output cfb_pkg::cfg_regs_t              regs
);
	import cfb_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.head_first  <= HEAD_FIRST_RST;
			regs_q.head_second <= HEAD_SECOND_RST;
			regs_q.tail_first  <= TAIL_FIRST_RST;
			regs_q.tail_second <= TAIL_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEAD_FIRST:  regs_q.head_first  <= cfg_data;
				CFG_HEAD_SECOND: regs_q.head_second <= cfg_data;
				CFG_TAIL_FIRST:  regs_q.tail_first  <= cfg_data;
				CFG_TAIL_SECOND: regs_q.tail_second <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== hdl/cfb_serializer.sv =====
// ----------------------------------------------------------------------------
// cfb_serializer
// Input register and byte sequencer: holds one item and steps through its
// bytes one per cycle unless stalled, keeping the running CRC and frame state.
// ----------------------------------------------------------------------------
module cfb_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  cfb_pkg::in_item_t   item,
	input  cfb_pkg::cfg_regs_t  regs,
	input  logic                emit_ready,
	output logic                emit,
	output cfb_pkg::out_item_t  emit_data
);
	import cfb_pkg::*;

	logic              s1_valid_q;
	in_item_t          s1_q;
	logic [POS_W-1:0]  pos_q;
	logic [15:0]       crc_q;
	logic [15:0]       rem_q;
	logic              open_q;

	logic        drop;
	logic        finish_now;
	logic        last;
	logic        done;
	logic        accept;
	logic        crc_byte_en;
	logic [7:0]  byte_sel;

	// A payload item with no frame open is retired without any byte.
	assign drop = s1_valid_q && (s1_q.mode == MODE_PAYLOAD) && !open_q;

	assign finish_now = (s1_q.mode == MODE_PAYLOAD) ? (rem_q == 16'd1)
	                                                : (s1_q.payload_length == 16'd0);

	always_comb begin
		byte_sel    = 8'h00;
		crc_byte_en = 1'b0;
		case (pos_q)
			POS_HEAD0:   byte_sel = regs.head_first;
			POS_HEAD1:   byte_sel = regs.head_second;
			POS_ADDR_HI: begin byte_sel = s1_q.module_address[15:8]; crc_byte_en = 1'b1; end
			POS_ADDR_LO: begin byte_sel = s1_q.module_address[7:0];  crc_byte_en = 1'b1; end
			POS_CMD_HI:  begin byte_sel = s1_q.command_code[15:8];   crc_byte_en = 1'b1; end
			POS_CMD_LO:  begin byte_sel = s1_q.command_code[7:0];    crc_byte_en = 1'b1; end
			POS_LEN_HI:  begin byte_sel = s1_q.payload_length[15:8]; crc_byte_en = 1'b1; end
			POS_LEN_LO: begin
				byte_sel    = (s1_q.mode == MODE_PAYLOAD) ? s1_q.payload_byte
				                                          : s1_q.payload_length[7:0];
				crc_byte_en = 1'b1;
			end
			POS_CRC_HI:  byte_sel = crc_q[15:8];
			POS_CRC_LO:  byte_sel = crc_q[7:0];
			POS_TAIL0:   byte_sel = regs.tail_first;
			POS_TAIL1:   byte_sel = regs.tail_second;
			default:     byte_sel = 8'h00;
		endcase
	end

	assign last = (pos_q == POS_TAIL1) || ((pos_q == POS_LEN_LO) && !finish_now);

	assign emit       = s1_valid_q && !drop && emit_ready;
	assign done       = drop || (emit && last);
	assign item_stall = s1_valid_q && !done;
	assign accept     = item_valid && !item_stall;

	assign emit_data.out_byte  = byte_sel;
	assign emit_data.frame_end = (pos_q == POS_TAIL1);
	assign emit_data.run_last  = last;

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			pos_q      <= POS_HEAD0;
			crc_q      <= 16'h0000;
			rem_q      <= 16'h0000;
			open_q     <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				pos_q      <= (item.mode == MODE_PAYLOAD) ? POS_LEN_LO : POS_HEAD0;
			end else if (done) begin
				s1_valid_q <= 1'b0;
			end else if (emit) begin
				pos_q <= pos_q + 1'b1;
			end

			if (emit) begin
				if (pos_q == POS_HEAD0) begin
					crc_q <= 16'h0000;
				end else if (crc_byte_en) begin
					crc_q <= crc16_byte(crc_q, byte_sel);
				end

				if (pos_q == POS_LEN_LO) begin
					if (s1_q.mode == MODE_PAYLOAD) begin
						rem_q <= rem_q - 16'd1;
					end else begin
						rem_q  <= s1_q.payload_length;
						open_q <= 1'b1;
					end
				end

				if (pos_q == POS_TAIL1) begin
					open_q <= 1'b0;
					rem_q  <= 16'h0000;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (pos_q <= POS_TAIL1))
		else $error("byte position beyond the final tail byte");

	a_close_on_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (pos_q == POS_TAIL1)) |=> !open_q)
		else $error("frame still open after its final tail byte");

	a_open_on_header: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (pos_q == POS_LEN_LO) && (s1_q.mode == MODE_START))
		|=> (open_q && (rem_q == $past(s1_q.payload_length))))
		else $error("frame not opened with its length after the header");

	a_drop_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !open_q && (s1_q.mode == MODE_PAYLOAD)) |=> !$past(emit))
		else $error("payload byte outside a frame produced a byte");
`endif

endmodule

// ===== hdl/cfb_out_reg.sv =====
// ----------------------------------------------------------------------------
// cfb_out_reg
// Output register: holds one result byte until the downstream side takes it,
// and takes the next one in the same cycle as a transfer.
// ----------------------------------------------------------------------------
module cfb_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  cfb_pkg::out_item_t  load_data,
	output logic                load_ready,
	output logic                result_valid,
	input  logic                result_stall,
	output cfb_pkg::out_item_t  result
);
	import cfb_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign load_ready = !valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign result_valid = valid_q;
	assign result       = data_q;

endmodule

// ===== hdl/command_frame_builder_crc16.sv =====
// ----------------------------------------------------------------------------
// command_frame_builder_crc16
// Serializes command frames (head, address, command, length, payload,
// CRC-16/XMODEM, tail) into a byte stream.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                  | Direction
//  item     | item_valid, item_stall, item (in_item_t) | in
//  result   | result_valid, result_stall, result       | out
//  config   | cfg_we, cfg_index, cfg_data              | in
//
// A start item yields eight bytes (twelve at zero length), a payload item one
// (five when it closes the frame), a payload byte outside a frame none. Items
// are registered in the sequencer before their bytes pass to the output register.
// Reset clears the sequencer, frame state and output register and reloads the
// head and tail registers. A result stall on a full output register holds the
// sequencer; the next item is taken as the current one's last byte is loaded.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  cfb_pkg::in_item_t               item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output cfb_pkg::out_item_t              result,
	input  logic                            cfg_we,
	input  logic [cfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data
);
	import cfb_pkg::*;

	cfg_regs_t regs;
	logic      emit;
	logic      emit_ready;
	out_item_t emit_data;

	cfb_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	cfb_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.regs       (regs),
		.emit_ready (emit_ready),
		.emit       (emit),
		.emit_data  (emit_data)
	);

	cfb_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (emit),
		.load_data    (emit_data),
		.load_ready   (emit_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
